FILE: rtl/sap_pkg.sv
package sap_pkg;

   localparam int STAGES      = 6;
   localparam int SAMPLE_BITS = 24;
   localparam int STATE_BITS  = SAMPLE_BITS + 4;
   localparam int COEF_BITS   = 18;
   localparam int COEF_FRAC   = 17;
   localparam int GAIN_BITS   = 16;
   localparam int GAIN_FRAC   = 16;
   localparam int MIX_BITS    = 17;
   localparam int OP_A_BITS   = STATE_BITS + 1;
   localparam int OP_B_BITS   = COEF_BITS;
   localparam int PROD_BITS   = OP_A_BITS + OP_B_BITS;
   localparam int WIDE_BITS   = PROD_BITS + 1;
   localparam int STAGE_BITS  = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int PC_BITS     = 4;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(32768);
   localparam logic [MIX_BITS-1:0]  MIX_FULL   = MIX_BITS'(65536);

   localparam logic CH_LEFT  = 1'b0;
   localparam logic CH_RIGHT = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [STATE_BITS-1:0]  state_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic        [GAIN_BITS-1:0]   gain_type;
   typedef logic        [MIX_BITS-1:0]    mix_type;
   typedef logic signed [OP_A_BITS-1:0]   op_a_type;
   typedef logic signed [OP_B_BITS-1:0]   op_b_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;
   typedef logic        [STAGE_BITS-1:0]  stage_type;
   typedef logic        [PC_BITS-1:0]     pc_type;

   localparam wide_type STATE_MAX  = (wide_type'(1) <<< (STATE_BITS - 1)) - wide_type'(1);
   localparam wide_type STATE_MIN  = -STATE_MAX - wide_type'(1);
   localparam wide_type SAMPLE_MAX = (wide_type'(1) <<< (SAMPLE_BITS - 1)) - wide_type'(1);
   localparam wide_type SAMPLE_MIN = -SAMPLE_MAX - wide_type'(1);
   localparam wide_type HALF_GAIN  = wide_type'(1) <<< (GAIN_FRAC - 1);
   localparam wide_type HALF_COEF  = wide_type'(1) <<< (COEF_FRAC - 1);

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FB,
      MUL_V,
      MUL_Y,
      MUL_D
   } mul_src_type;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_VIN,
      ALU_Y,
      ALU_Z,
      ALU_DIFF,
      ALU_OUT
   } alu_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_WAIT,
      SEQ_END
   } seq_op_type;

   localparam pc_type PC_LOOP_TOP = PC_BITS'(3);

   typedef struct packed {
      mul_src_type mul_src;
      logic        mul_ch;
      alu_op_type  alu_op;
      logic        alu_ch;
      seq_op_type  seq;
      pc_type      target;
   } ucode_type;

   typedef struct packed {
      logic        load;
      logic        adv;
      stage_type   stage;
      mul_src_type mul_src;
      logic        mul_ch;
      alu_op_type  alu_op;
      logic        alu_ch;
   } ctrl_type;

   function automatic ucode_type uword(input mul_src_type ms, input logic mc,
                                       input alu_op_type ao, input logic ac,
                                       input seq_op_type sq);
      ucode_type w;
      w.mul_src = ms;
      w.mul_ch  = mc;
      w.alu_op  = ao;
      w.alu_ch  = ac;
      w.seq     = sq;
      w.target  = PC_LOOP_TOP;
      return w;
   endfunction

   // Program: channels interleaved so the multiplier and the ALU are both busy in the section loop.
   // Steps 3..6 form the section loop; step 6 also starts the next section.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         PC_BITS'(0):  w = uword(MUL_FB,   CH_LEFT,  ALU_NOP,  CH_LEFT,  SEQ_NEXT);
         PC_BITS'(1):  w = uword(MUL_FB,   CH_RIGHT, ALU_VIN,  CH_LEFT,  SEQ_NEXT);
         PC_BITS'(2):  w = uword(MUL_V,    CH_LEFT,  ALU_VIN,  CH_RIGHT, SEQ_NEXT);
         PC_BITS'(3):  w = uword(MUL_V,    CH_RIGHT, ALU_Y,    CH_LEFT,  SEQ_NEXT);
         PC_BITS'(4):  w = uword(MUL_Y,    CH_LEFT,  ALU_Y,    CH_RIGHT, SEQ_NEXT);
         PC_BITS'(5):  w = uword(MUL_Y,    CH_RIGHT, ALU_Z,    CH_LEFT,  SEQ_NEXT);
         PC_BITS'(6):  w = uword(MUL_V,    CH_LEFT,  ALU_Z,    CH_RIGHT, SEQ_LOOP);
         PC_BITS'(7):  w = uword(MUL_NONE, CH_LEFT,  ALU_DIFF, CH_LEFT,  SEQ_NEXT);
         PC_BITS'(8):  w = uword(MUL_D,    CH_LEFT,  ALU_DIFF, CH_RIGHT, SEQ_NEXT);
         PC_BITS'(9):  w = uword(MUL_D,    CH_RIGHT, ALU_OUT,  CH_LEFT,  SEQ_WAIT);
         PC_BITS'(10): w = uword(MUL_NONE, CH_LEFT,  ALU_OUT,  CH_RIGHT, SEQ_END);
         default:      w = uword(MUL_NONE, CH_LEFT,  ALU_NOP,  CH_LEFT,  SEQ_END);
      endcase
      return w;
   endfunction

   function automatic state_type sat_state(input wide_type x);
      state_type r;
      if (x > STATE_MAX) begin
         r = STATE_MAX[STATE_BITS-1:0];
      end else if (x < STATE_MIN) begin
         r = STATE_MIN[STATE_BITS-1:0];
      end else begin
         r = x[STATE_BITS-1:0];
      end
      return r;
   endfunction

   function automatic sample_type sat_sample(input wide_type x);
      sample_type r;
      if (x > SAMPLE_MAX) begin
         r = SAMPLE_MAX[SAMPLE_BITS-1:0];
      end else if (x < SAMPLE_MIN) begin
         r = SAMPLE_MIN[SAMPLE_BITS-1:0];
      end else begin
         r = x[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/sap_seq.sv
module sap_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output sap_pkg::ctrl_type   ctrl
);

   logic                 run_ff, run_in;
   sap_pkg::pc_type      pc_ff, pc_in;
   sap_pkg::stage_type   stage_ff, stage_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sap_pkg::ucode_type   uc;
   logic                 accept;
   logic                 stall;
   logic                 adv;

   assign uc     = sap_pkg::ucode_rom(pc_ff);
   assign accept = req_tvalid && !run_ff;
   assign stall  = (uc.seq == sap_pkg::SEQ_WAIT) && rsp_valid_ff && !rsp_tready;
   assign adv    = run_ff && !stall;

   always_comb begin
      run_in   = run_ff;
      pc_in    = pc_ff;
      stage_in = stage_ff;
      if (accept) begin
         run_in   = 1'b1;
         pc_in    = '0;
         stage_in = '0;
      end else if (adv) begin
         case (uc.seq)
            sap_pkg::SEQ_NEXT, sap_pkg::SEQ_WAIT: begin
               pc_in = pc_ff + sap_pkg::PC_BITS'(1);
            end
            sap_pkg::SEQ_LOOP: begin
               if (stage_ff == sap_pkg::STAGE_BITS'(sap_pkg::STAGES - 1)) begin
                  pc_in = pc_ff + sap_pkg::PC_BITS'(1);
               end else begin
                  pc_in    = uc.target;
                  stage_in = stage_ff + sap_pkg::STAGE_BITS'(1);
               end
            end
            sap_pkg::SEQ_END: begin
               run_in = 1'b0;
            end
            default: begin
               run_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (adv && (uc.seq == sap_pkg::SEQ_END)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         pc_ff        <= '0;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         pc_ff        <= pc_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = !run_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      ctrl.load    = accept;
      ctrl.adv     = adv;
      ctrl.stage   = stage_ff;
      ctrl.mul_src = uc.mul_src;
      ctrl.mul_ch  = uc.mul_ch;
      ctrl.alu_op  = uc.alu_op;
      ctrl.alu_ch  = uc.alu_ch;
   end

endmodule

FILE: rtl/sap_dp.sv
module sap_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  sap_pkg::ctrl_type     ctrl,
   input  logic                  csr_we,
   input  sap_pkg::gain_type     csr_wdata,
   input  sap_pkg::sample_type   left_in,
   input  sap_pkg::sample_type   right_in,
   input  sap_pkg::coef_type     allpass_coefficient,
   input  sap_pkg::mix_type      mix_amount,
   output sap_pkg::sample_type   left_out,
   output sap_pkg::sample_type   right_out
);

   sap_pkg::gain_type    gain_ff;
   sap_pkg::sample_type  dry_ff [2];
   sap_pkg::coef_type    coef_ff;
   sap_pkg::mix_type     mix_ff;
   sap_pkg::state_type   fb_ff  [2];
   sap_pkg::state_type   fb_in  [2];
   sap_pkg::state_type   mem_ff [2][sap_pkg::STAGES];
   sap_pkg::state_type   mem_in [2][sap_pkg::STAGES];
   sap_pkg::state_type   v_ff   [2];
   sap_pkg::state_type   v_in   [2];
   sap_pkg::state_type   y_ff   [2];
   sap_pkg::state_type   y_in   [2];
   sap_pkg::op_a_type    d_ff, d_in;
   sap_pkg::prod_type    prod_ff, prod_in;
   sap_pkg::sample_type  left_ff, left_d_in;
   sap_pkg::sample_type  right_ff, right_d_in;

   sap_pkg::op_a_type    op_a;
   sap_pkg::op_b_type    op_b;
   sap_pkg::wide_type    rnd_gain;
   sap_pkg::wide_type    rnd_coef;
   sap_pkg::wide_type    dry_w;
   sap_pkg::state_type   fbp;
   sap_pkg::state_type   effect;
   sap_pkg::wide_type    diff_w;
   logic                 ch;

   // multiplier operand select
   always_comb begin
      case (ctrl.mul_src)
         sap_pkg::MUL_FB: begin
            op_a = sap_pkg::op_a_type'(fb_ff[ctrl.mul_ch]);
            op_b = sap_pkg::op_b_type'(gain_ff);
         end
         sap_pkg::MUL_V: begin
            op_a = sap_pkg::op_a_type'(v_ff[ctrl.mul_ch]);
            op_b = coef_ff;
         end
         sap_pkg::MUL_Y: begin
            op_a = sap_pkg::op_a_type'(y_ff[ctrl.mul_ch]);
            op_b = coef_ff;
         end
         sap_pkg::MUL_D: begin
            op_a = d_ff;
            op_b = sap_pkg::op_b_type'(mix_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = sap_pkg::prod_type'(op_a) * sap_pkg::prod_type'(op_b);

   // rounded products, add half then floor
   assign rnd_gain = (sap_pkg::wide_type'(prod_ff) + sap_pkg::HALF_GAIN) >>> sap_pkg::GAIN_FRAC;
   assign rnd_coef = (sap_pkg::wide_type'(prod_ff) + sap_pkg::HALF_COEF) >>> sap_pkg::COEF_FRAC;

   assign ch    = ctrl.alu_ch;
   assign dry_w = sap_pkg::wide_type'(dry_ff[ch]);

   always_comb begin
      fb_in      = fb_ff;
      mem_in     = mem_ff;
      v_in       = v_ff;
      y_in       = y_ff;
      d_in       = d_ff;
      left_d_in  = left_ff;
      right_d_in = right_ff;
      fbp        = sap_pkg::sat_state(rnd_gain);
      effect     = sap_pkg::sat_state((dry_w + sap_pkg::wide_type'(v_ff[ch])
                                       + sap_pkg::wide_type'(1)) >>> 1);
      diff_w     = sap_pkg::wide_type'(effect) - dry_w;
      case (ctrl.alu_op)
         sap_pkg::ALU_VIN: begin
            v_in[ch] = sap_pkg::sat_state(dry_w + sap_pkg::wide_type'(fbp));
         end
         sap_pkg::ALU_Y: begin
            y_in[ch] = sap_pkg::sat_state(rnd_coef
                                          + sap_pkg::wide_type'(mem_ff[ch][ctrl.stage]));
         end
         sap_pkg::ALU_Z: begin
            mem_in[ch][ctrl.stage] = sap_pkg::sat_state(sap_pkg::wide_type'(v_ff[ch])
                                                        - rnd_coef);
            v_in[ch] = y_ff[ch];
         end
         sap_pkg::ALU_DIFF: begin
            d_in      = diff_w[sap_pkg::OP_A_BITS-1:0];
            fb_in[ch] = v_ff[ch];
         end
         sap_pkg::ALU_OUT: begin
            if (ch == sap_pkg::CH_LEFT) begin
               left_d_in = sap_pkg::sat_sample(dry_w + rnd_gain);
            end else begin
               right_d_in = sap_pkg::sat_sample(dry_w + rnd_gain);
            end
         end
         default: begin
            d_in = d_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= sap_pkg::GAIN_RESET;
         for (int c = 0; c < 2; c++) begin
            fb_ff[c] <= '0;
            for (int s = 0; s < sap_pkg::STAGES; s++) begin
               mem_ff[c][s] <= '0;
            end
         end
      end else begin
         if (csr_we) begin
            gain_ff <= csr_wdata;
         end
         if (ctrl.adv) begin
            fb_ff  <= fb_in;
            mem_ff <= mem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         dry_ff[sap_pkg::CH_LEFT]  <= left_in;
         dry_ff[sap_pkg::CH_RIGHT] <= right_in;
         coef_ff                   <= allpass_coefficient;
         mix_ff                    <= (mix_amount > sap_pkg::MIX_FULL) ? sap_pkg::MIX_FULL
                                                                       : mix_amount;
      end
      if (ctrl.adv) begin
         v_ff     <= v_in;
         y_ff     <= y_in;
         d_ff     <= d_in;
         prod_ff  <= prod_in;
         left_ff  <= left_d_in;
         right_ff <= right_d_in;
      end
   end

   assign left_out  = left_ff;
   assign right_out = right_ff;

endmodule

FILE: rtl/stereo_allpass_phaser_unit.sv
// Stereo six-section all-pass phaser. Each req beat carries a stereo sample pair, the
// all-pass coefficient and the blend amount; each rsp beat returns the blended pair.
// Each item is taken in, then run through 31 microcode steps on the single shared
// 29x18 multiplier, which uses 28 products per item (feedback, two per section and
// blend, for each channel). req_tready is high whenever no item is in work, also while
// a finished result waits in the rsp register; an unread result holds the sequencer at
// the step that starts writing the next result. csr_wdata sets the Q0.16 feedback gain
// (reset 0.5); the user must write it only while the block is idle, as it is not enforced.
module stereo_allpass_phaser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // left_in, right_in, allpass_coefficient, mix_amount
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // left_out, right_out
);

   sap_pkg::ctrl_type   ctrl;
   sap_pkg::sample_type left_out;
   sap_pkg::sample_type right_out;

   sap_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   sap_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .left_in             (req_tdata[23:0]),
      .right_in            (req_tdata[47:24]),
      .allpass_coefficient (req_tdata[65:48]),
      .mix_amount          (req_tdata[82:66]),
      .left_out            (left_out),
      .right_out           (right_out)
   );

   assign rsp_tdata = {right_out, left_out};

endmodule

FILE: tb/sv/phaser_checker.sv
`timescale 1ns / 100ps

module phaser_checker
   import sap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          mismatch_count,
   output int          pending_beats,
   output int          result_count
);

   typedef struct {
      sample_type left;
      sample_type right;
   } stereo_pair_type;

   stereo_pair_type expected_pairs[$];
   longint     section_z[2][STAGES];
   longint     cascade_fb[2];
   gain_type   fb_gain;
   int         fail_total;
   int         results_seen;

   assign mismatch_count = fail_total;
   assign result_count   = results_seen;

   function automatic longint clamp(input longint x, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
         return hi;
      end else if (x < lo) begin
         return lo;
      end
      return x;
   endfunction

   // add half, then floor
   function automatic longint round_shift(input longint x, input int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint phase_channel(input int ch, input longint dry,
                                            input longint c, input longint mix);
      longint fb;
      longint v;
      longint y;
      longint wet;
      longint delta;
      int     s;
      fb = clamp(round_shift(cascade_fb[ch] * longint'(fb_gain), GAIN_FRAC), STATE_BITS);
      v  = clamp(dry + fb, STATE_BITS);
      for (s = 0; s < STAGES; s++) begin
         y = clamp(round_shift(c * v, COEF_FRAC) + section_z[ch][s], STATE_BITS);
         section_z[ch][s] = clamp(v - round_shift(c * y, COEF_FRAC), STATE_BITS);
         v = y;
      end
      cascade_fb[ch] = v;
      wet   = clamp((dry + v + 1) >>> 1, STATE_BITS);
      delta = round_shift((wet - dry) * mix, GAIN_FRAC);
      return clamp(dry + delta, SAMPLE_BITS);
   endfunction

   function automatic void note_mismatch(input string what, input longint exp_val,
                                         input longint got_val);
      fail_total++;
      if (fail_total <= 10) begin
         $display("%s mismatch at %0t: expected %0d, got %0d",
                  what, $realtime, exp_val, got_val);
      end
   endfunction

   always @(posedge clock) begin
      stereo_pair_type exp_pair;
      sample_type got_l;
      sample_type got_r;
      sample_type in_l;
      sample_type in_r;
      coef_type   in_c;
      longint     mix;
      if (reset) begin
         expected_pairs.delete();
         foreach (section_z[ch, s]) section_z[ch][s] = 0;
         cascade_fb[0] = 0;
         cascade_fb[1] = 0;
         fb_gain = GAIN_RESET;
      end else begin
         if (csr_we) begin
            fb_gain = csr_wdata;
         end
         // older item first: a result beat never belongs to the beat taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got_l = rsp_tdata[23:0];
            got_r = rsp_tdata[47:24];
            if (expected_pairs.size() == 0) begin
               note_mismatch("unexpected rsp beat, left_out", 0, got_l);
            end else begin
               exp_pair = expected_pairs.pop_front();
               if (got_l !== exp_pair.left) begin
                  note_mismatch("left_out", exp_pair.left, got_l);
               end
               if (got_r !== exp_pair.right) begin
                  note_mismatch("right_out", exp_pair.right, got_r);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            in_l = req_tdata[23:0];
            in_r = req_tdata[47:24];
            in_c = req_tdata[65:48];
            mix  = longint'(req_tdata[82:66]);
            if (mix > longint'(MIX_FULL)) begin
               mix = longint'(MIX_FULL);
            end
            exp_pair.left  = sample_type'(phase_channel(0, in_l, in_c, mix));
            exp_pair.right = sample_type'(phase_channel(1, in_r, in_c, mix));
            expected_pairs.push_back(exp_pair);
         end
      end
      pending_beats <= expected_pairs.size();
   end

   initial begin
      fail_total    = 0;
      results_seen  = 0;
      pending_beats = 0;
      fb_gain       = GAIN_RESET;
   end

endmodule

FILE: tb/sv/tb_stereo_allpass_phaser_unit.sv
`timescale 1ns / 100ps

module tb_stereo_allpass_phaser_unit;
   import sap_pkg::*;

   localparam int          PHASES        = 8;
   localparam int          PHASE_ITEMS   = 250;
   localparam int          HOLD_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam coef_type    COEF_MAX      = 18'sh1FFFF;
   localparam coef_type    COEF_MIN      = 18'sh20000;
   localparam sample_type  SMP_MAX       = 24'sh7FFFFF;
   localparam sample_type  SMP_MIN       = 24'sh800000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [15:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;   // left_in, right_in, allpass_coefficient, mix_amount
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // left_out, right_out

   int          mismatch_count;
   int          pending_beats;
   int          result_count;
   int unsigned cycle_count;
   int          items_sent;
   int          gain_writes;
   bit          idle_on;
   bit          hold_req;
   coef_type    lfo_coef;
   int          lfo_step;

   stereo_allpass_phaser_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   phaser_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_beats  (pending_beats),
      .result_count   (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   // rsp side: random stall bursts, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_pair(input sample_type l, input sample_type r,
                            input coef_type c, input mix_type m);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, m, c, r, l};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   task automatic write_gain(input gain_type g);
      csr_we    <= 1'b1;
      csr_wdata <= g;
      @(posedge clock);
      csr_we    <= 1'b0;
      gain_writes++;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return SMP_MAX;
         1: return SMP_MIN;
         2: return sample_type'($urandom_range(0, 1) ? 0 : -1);
         3, 4: return sample_type'(int'($urandom_range(0, 8191)) - 4096);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic mix_type pick_mix();
      case ($urandom_range(0, 9))
         0: return MIX_FULL;
         1: return mix_type'(0);
         2: return mix_type'($urandom_range(65537, 131071));
         default: return mix_type'($urandom_range(0, 65536));
      endcase
   endfunction

   // slow coefficient sweep as a host LFO would produce, with occasional jumps; only jumps when sweep is off
   function automatic coef_type next_coef(input bit sweep);
      int nxt;
      if (!sweep || $urandom_range(0, 19) == 0) begin
         case ($urandom_range(0, 7))
            0: return COEF_MAX;
            1: return COEF_MIN;
            default: return coef_type'($urandom);
         endcase
      end
      nxt = int'(lfo_coef) + lfo_step;
      if (nxt > int'(COEF_MAX) || nxt < int'(COEF_MIN)) begin
         lfo_step = -lfo_step;
         nxt = int'(lfo_coef) + lfo_step;
      end
      lfo_coef = coef_type'(nxt);
      return lfo_coef;
   endfunction

   initial begin
      gain_type gain_plan[PHASES];
      int       p;
      int       k;
      gain_plan = '{16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'hFFFF, 16'd0, 16'd32768, 16'hC000};
      gain_plan[3] = gain_type'($urandom);
      gain_plan[6] = gain_type'($urandom);
      cycle_count = 0;
      items_sent  = 0;
      gain_writes = 0;
      idle_on     = 1'b1;
      hold_req    = 1'b0;
      lfo_coef    = '0;
      lfo_step    = 600;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, mix above full, coefficient of minus one
      push_pair('0, '0, '0, '0);
      push_pair(SMP_MAX, SMP_MAX, COEF_MAX, MIX_FULL);
      push_pair(SMP_MIN, SMP_MIN, COEF_MIN, MIX_FULL);
      push_pair(SMP_MAX, SMP_MIN, COEF_MIN, mix_type'(131071));
      push_pair(SMP_MIN, SMP_MAX, COEF_MAX, mix_type'(65537));
      push_pair(SMP_MAX, SMP_MIN, COEF_MAX, '0);
      push_pair(24'shAAAAAA, 24'sh555555, 18'sh2AAAA, mix_type'(17'h15555));
      push_pair(24'sh555555, 24'shAAAAAA, 18'sh15555, mix_type'(17'h0AAAA));
      push_pair(sample_type'(-1), sample_type'(1), '0, MIX_FULL);
      for (k = 0; k < 6; k++) begin
         push_pair(SMP_MAX, SMP_MIN, COEF_MIN, MIX_FULL);
      end
      for (k = 0; k < 4; k++) begin
         push_pair(SMP_MIN, SMP_MAX, COEF_MAX, mix_type'(100000));
      end
      push_pair(sample_type'(1), sample_type'(-1), 18'sh00001, mix_type'(1));
      push_pair('0, '0, '0, MIX_FULL);

      for (p = 0; p < PHASES; p++) begin
         drain_block();
         write_gain(gain_plan[p]);
         idle_on = (p != 4) && (p != PHASES - 1);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 20) begin
               hold_req = 1'b1;
            end
            push_pair(pick_sample(), pick_sample(), next_coef(p % 2 == 0), pick_mix());
         end
      end

      drain_block();
      repeat (64) @(posedge clock);
      $display("Sent %0d sample pairs, checked %0d result beats", items_sent, result_count);
      $display("Feedback gain written %0d times, including 0 and 0xFFFF", gain_writes);
      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Left over %0d, mismatches %0d", pending_beats, mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
